FILE: sv/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked on every rising edge, quiet while reset is asserted
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/dsm_pkg.sv
package dsm_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned POS_W         = 32;
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned NUM_WORDS     = 4;
  localparam int unsigned PAT_BYTES     = 32;
  localparam int unsigned ALPHABET_SIZE = 256;
  localparam int unsigned CFG_IDX_W     = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH = 3'd0,
    CFG_WORD0  = 3'd1,
    CFG_WORD1  = 3'd2,
    CFG_WORD2  = 3'd3,
    CFG_WORD3  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              last_of_text;
  } in_item_t;

  typedef struct packed {
    logic             match_found;
    logic [POS_W-1:0] match_start;
  } out_item_t;

  // table builder status seen by the matching core
  typedef struct packed {
    logic             busy;
    logic [LEN_W-1:0] act_len;
  } status_t;

endpackage

FILE: sv/dsm_border.sv
`include "assert_macros.svh"

module dsm_border #(
  parameter int unsigned LIM = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [dsm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dsm_pkg::WORD_W-1:0]          cfg_data_i,
  output dsm_pkg::status_t                    status_o,
  output logic [LIM-1:0][dsm_pkg::BYTE_W-1:0] pat_o,
  output logic [LIM-1:0][LIM-1:0]             border_o
);
  import dsm_pkg::*;

  localparam int unsigned RW = $clog2(LIM + 1);
  localparam int unsigned IW = (LIM > 1) ? $clog2(LIM) : 1;

  logic [LEN_W-1:0]                len_q;
  logic [NUM_WORDS-1:0][WORD_W-1:0] words_q;
  logic                            busy_q;
  logic [RW-1:0]                   row_q;
  logic [RW-1:0]                   row_m1;
  logic [IW-1:0]                   row_idx;
  logic [LIM-1:0]                  prev_q;
  logic [LIM-1:0]                  new_row;
  logic [BYTE_W-1:0]               last_byte;
  logic [LIM-1:0][LIM-1:0]         border_q;
  logic                            word_wr;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LEN_W'(1);
      words_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LENGTH: len_q      <= cfg_data_i[LEN_W-1:0];
        CFG_WORD0:  words_q[0] <= cfg_data_i;
        CFG_WORD1:  words_q[1] <= cfg_data_i;
        CFG_WORD2:  words_q[2] <= cfg_data_i;
        CFG_WORD3:  words_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign word_wr = cfg_valid_i && (cfg_index_i == CFG_WORD0 || cfg_index_i == CFG_WORD1 ||
                                   cfg_index_i == CFG_WORD2 || cfg_index_i == CFG_WORD3);

  // pattern bytes unpacked from the words
  for (genvar i = 0; i < LIM; i++) begin : g_pat
    assign pat_o[i] = words_q[i/8][(i%8)*BYTE_W +: BYTE_W];
  end

  // active length: zero acts as one, clamp to table size
  always_comb begin
    status_o.busy = busy_q;
    if (len_q == '0) begin
      status_o.act_len = LEN_W'(1);
    end else if (len_q > LEN_W'(LIM)) begin
      status_o.act_len = LEN_W'(LIM);
    end else begin
      status_o.act_len = len_q;
    end
  end

  // next border row: prefix j of row r extends prefix j-1 of row r-1
  assign row_m1    = row_q - RW'(1);
  assign row_idx   = row_m1[IW-1:0];
  assign last_byte = pat_o[row_idx];

  always_comb begin
    new_row    = '0;
    new_row[0] = 1'b1;
    for (int j = 1; j < LIM; j++) begin
      new_row[j] = prev_q[j-1] & (pat_o[j-1] == last_byte);
    end
  end

  // build sweep, one row a cycle, restarted by every pattern write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      row_q  <= RW'(1);
      prev_q <= LIM'(1);
    end else if (word_wr) begin
      busy_q <= 1'b1;
      row_q  <= RW'(1);
      prev_q <= LIM'(1);
    end else if (busy_q) begin
      prev_q <= new_row;
      if (row_q == RW'(LIM)) begin
        busy_q <= 1'b0;
      end else begin
        row_q <= row_q + RW'(1);
      end
    end
  end

  // border table rows 1..LIM
  always_ff @(posedge clk_i) begin
    if (busy_q && !word_wr) begin
      border_q[row_idx] <= new_row;
    end
  end

  assign border_o = border_q;

  `ASSERT_CHK(a_row_range, busy_q |-> (row_q != '0 && row_q <= RW'(LIM)),
              "build row out of range")
  `ASSERT_CHK(a_done_last_row, $fell(busy_q) |-> $past(row_q) == RW'(LIM),
              "build ended before the last row")
  `ASSERT_CHK(a_restart, word_wr |=> busy_q && row_q == RW'(1),
              "pattern write did not restart the build")

endmodule

FILE: sv/dsm_core.sv
`include "assert_macros.svh"

module dsm_core #(
  parameter int unsigned LIM = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dsm_pkg::status_t                    status_i,
  input  logic [LIM-1:0][dsm_pkg::BYTE_W-1:0] pat_i,
  input  logic [LIM-1:0][LIM-1:0]             border_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dsm_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output dsm_pkg::out_item_t                  out_data_o
);
  import dsm_pkg::*;

  localparam int unsigned IW = (LIM > 1) ? $clog2(LIM) : 1;
  localparam logic [BYTE_W:0] ALPH_EXT = (BYTE_W + 1)'(ALPHABET_SIZE);

  logic             s0_valid_q;
  in_item_t         s0_data_q;
  logic             out_valid_q;
  out_item_t        out_data_q;
  logic [LEN_W-1:0] state_q;
  logic [POS_W-1:0] pos_q;
  logic             adv;
  logic             take;
  logic [LEN_W-1:0] m;
  logic [LEN_W-1:0] q_eff;
  logic [LEN_W-1:0] q_m1;
  logic [LIM-1:0]   row;
  logic [LIM-1:0]   cand;
  logic [LEN_W-1:0] k;
  logic             hit;

  // handshake: input register moves on when the result register frees up and no build runs
  assign adv        = s0_valid_q && !status_i.busy && (!out_valid_q || !out_stall_i);
  assign in_stall_o = status_i.busy || (s0_valid_q && !adv);
  assign take       = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (take) begin
      s0_valid_q <= 1'b1;
    end else if (adv) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s0_data_q <= in_data_i;
    end
  end

  // current state, restarted from zero if above the length in use
  assign m     = status_i.act_len;
  assign q_eff = (state_q > m) ? '0 : state_q;
  assign q_m1  = q_eff - LEN_W'(1);

  // border row of the current state
  always_comb begin
    row = '0;
    if (q_eff == '0) begin
      row[0] = 1'b1;
    end else begin
      row = border_i[q_m1[IW-1:0]];
    end
  end

  // longest prefix that the new byte extends
  always_comb begin
    for (int j = 0; j < LIM; j++) begin
      cand[j] = row[j] & (pat_i[j] == s0_data_q.text_byte) & (LEN_W'(j) < m);
    end
    k = '0;
    for (int j = 0; j < LIM; j++) begin
      if (cand[j]) begin
        k = LEN_W'(j + 1);
      end
    end
    if ({1'b0, s0_data_q.text_byte} >= ALPH_EXT) begin
      k = '0;
    end
  end

  assign hit = (k == m);

  // automaton state and byte position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      pos_q   <= '0;
    end else if (adv) begin
      if (s0_data_q.last_of_text) begin
        state_q <= '0;
        pos_q   <= '0;
      end else begin
        state_q <= k;
        if (pos_q != '1) begin
          pos_q <= pos_q + POS_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q.match_found <= hit;
      out_data_q.match_start <= hit ? (pos_q - POS_W'(m) + POS_W'(1)) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_CHK(a_busy_stalls, status_i.busy |-> in_stall_o && !adv,
              "item moved while the table was being built")
  `ASSERT_CHK(a_state_range, state_q <= LEN_W'(LIM),
              "automaton state above table size")
  `ASSERT_CHK(a_last_clears, adv && s0_data_q.last_of_text |=> state_q == '0 && pos_q == '0,
              "end of text did not clear state")
  `ASSERT_CHK(a_no_hit_zero, out_valid_q && !out_data_q.match_found |->
              out_data_q.match_start == '0, "start position set without a match")

endmodule

FILE: sv/dfa_string_matcher.sv
// exact single-pattern matcher over a byte stream
//
// input channel: one text byte per item plus a last-of-text flag, valid/stall.
// output channel: one result per item, a match flag and the start position
// of the occurrence that ends at that byte, valid/stall.
// config channel: valid/ready, always ready; index 0 is the pattern length,
// indexes 1 to 4 the pattern words, higher indexes are ignored.
//
// an accepted item waits in the input register, its result in the result
// register. throughput: one item per cycle unless a build runs or the
// receiver stalls, set by the automaton state feedback through the border
// row select and the prefix priority pick. reset, and every pattern word
// write, starts a build of the border table, one row per cycle; input stall
// stays high meanwhile. state and position reset to zero, length to one,
// pattern to zero. a stalled receiver holds the result register; one more
// item can wait in the input register, after which the input is stalled.
module dfa_string_matcher #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dsm_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dsm_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dsm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dsm_pkg::WORD_W-1:0]    cfg_data_i
);
  import dsm_pkg::*;

  localparam int unsigned LIM = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;

  status_t                     status;
  logic [LIM-1:0][BYTE_W-1:0]  pat;
  logic [LIM-1:0][LIM-1:0]     border;

  assign cfg_ready_o = 1'b1;

  // configuration and border table builder
  dsm_border #(
    .LIM (LIM)
  ) u_border (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (status),
    .pat_o       (pat),
    .border_o    (border)
  );

  // matching pipeline
  dsm_core #(
    .LIM (LIM)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .status_i    (status),
    .pat_i       (pat),
    .border_i    (border),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: verif/match_checker.sv
`timescale 1ns / 1ps

// watches the text, result and config channels, tracks the matcher state and
// compares every result against the predicted one
module match_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  dsm_pkg::in_item_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  dsm_pkg::out_item_t            out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [dsm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dsm_pkg::WORD_W-1:0]    cfg_data_i,
  output int                            pending_o,
  output int                            mismatches_o
);
  import dsm_pkg::*;

  localparam int MAX_REPORTS = 10;

  // mirrored configuration
  logic [LEN_W-1:0]  pat_len;
  logic [WORD_W-1:0] pat_word [NUM_WORDS];

  // mirrored automaton
  logic [LEN_W-1:0]  prefix_len;
  logic [POS_W-1:0]  text_pos;

  out_item_t expected_hits [$];
  int        mismatch_cnt;

  // pattern byte i, zero past the stored words
  function automatic logic [BYTE_W-1:0] pat_byte(int unsigned i);
    if (i >= PAT_BYTES) return '0;
    return pat_word[i / 8][(i % 8) * 8 +: 8];
  endfunction

  // longest pattern prefix that is a suffix of prefix(q) followed by c
  function automatic int unsigned next_prefix(int unsigned q, logic [BYTE_W-1:0] c,
                                              int unsigned m);
    int unsigned k;
    int unsigned off;
    int unsigned i;
    bit ok;
    k = (q + 1 < m) ? q + 1 : m;
    while (k > 0) begin
      off = q + 1 - k;
      ok = (pat_byte(k - 1) == c);
      i = 0;
      while (ok && i + 1 < k) begin
        if (pat_byte(i) != pat_byte(off + i)) ok = 0;
        i++;
      end
      if (ok) return k;
      k--;
    end
    return 0;
  endfunction

  // expected result for one text byte; advances the mirrored automaton
  function automatic out_item_t predict_match(in_item_t item);
    int unsigned m;
    int unsigned q;
    out_item_t res;
    m = (pat_len == '0) ? 32'd1 : 32'(pat_len);
    if (m > PAT_BYTES) m = PAT_BYTES;
    q = 32'(prefix_len);
    // a length cut in mid-text restarts from the empty prefix
    if (q > m) q = 0;
    q = next_prefix(q, item.text_byte, m);
    res.match_found = (q == m);
    res.match_start = res.match_found ? text_pos - POS_W'(m) + POS_W'(1) : '0;
    if (item.last_of_text) begin
      prefix_len = '0;
      text_pos   = '0;
    end else begin
      prefix_len = LEN_W'(q);
      if (text_pos != '1) text_pos = text_pos + 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t got;
    out_item_t want;
    if (!rst_ni) begin
      pat_len = LEN_W'(1);
      foreach (pat_word[w]) pat_word[w] = '0;
      prefix_len = '0;
      text_pos = '0;
      expected_hits.delete();
      mismatch_cnt = 0;
    end else begin
      // accepted text item
      if (in_valid_i && !in_stall_i) expected_hits.push_back(predict_match(in_data_i));

      // accepted result
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (expected_hits.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: result with no item waiting: found=%0b start=%h",
                     $realtime, got.match_found, got.match_start);
        end else begin
          want = expected_hits.pop_front();
          if (got.match_found !== want.match_found ||
              got.match_start !== want.match_start) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("%0t: wrong result: expected found=%0b start=%h, got found=%0b start=%h",
                       $realtime, want.match_found, want.match_start,
                       got.match_found, got.match_start);
          end
        end
      end

      // register write, seen after the item of the same edge
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LENGTH: pat_len = cfg_data_i[LEN_W-1:0];
          CFG_WORD0:  pat_word[0] = cfg_data_i;
          CFG_WORD1:  pat_word[1] = cfg_data_i;
          CFG_WORD2:  pat_word[2] = cfg_data_i;
          CFG_WORD3:  pat_word[3] = cfg_data_i;
          default: ;  // spare indexes are ignored
        endcase
      end
    end
    pending_o    <= expected_hits.size();
    mismatches_o <= mismatch_cnt;
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dsm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int RANDOM_PHASES   = 14;
  localparam int ITEMS_PER_PHASE = 136;
  localparam int TOTAL_ITEMS     = 15 + RANDOM_PHASES * ITEMS_PER_PHASE;
  localparam int LAST_PCT        = 2;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [WORD_W-1:0]  cfg_data_i  = '0;

  int pending_results;
  int mismatches;
  int tx_idle_pct = 7;
  int rx_idle_pct = 56;
  int items_sent  = 0;

  // stimulus copy of the pattern, used to shape the text
  logic [BYTE_W-1:0] pat_bytes [PAT_BYTES];
  int unsigned       pat_len_eff = 1;
  logic [BYTE_W-1:0] text_q [$];

  logic [LEN_W-1:0] phase_len [RANDOM_PHASES] =
    '{6'd1, 6'd32, 6'd63, 6'd2, 6'd0, 6'd40, 6'd3, 6'd5,
      6'd17, 6'd8, 6'd33, 6'd1, 6'd16, 6'd31};

  dfa_string_matcher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  match_checker match_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending_results),
    .mismatches_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // one text byte, with random sender gaps in front
  task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
    in_item_t item;
    item.text_byte    = b;
    item.last_of_text = last;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    // idle profile: sender light, then receiver light, then none
    if (items_sent < TOTAL_ITEMS / 3) begin
      tx_idle_pct = 7;
      rx_idle_pct = 56;
    end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
      tx_idle_pct = 56;
      rx_idle_pct = 7;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  // register write; valid stays up for back-to-back writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_length(logic [LEN_W-1:0] len);
    write_reg(CFG_LENGTH, WORD_W'(len));
    pat_len_eff = (len == '0) ? 32'd1 : ((len > PAT_BYTES) ? PAT_BYTES : 32'(len));
  endtask

  task automatic write_words;
    logic [WORD_W-1:0] wd;
    for (int w = 0; w < NUM_WORDS; w++) begin
      for (int b = 0; b < 8; b++) wd[b * 8 +: 8] = pat_bytes[w * 8 + b];
      write_reg(cfg_idx_e'(CFG_WORD0 + w), wd);
    end
  endtask

  // random pattern: free bytes, two symbols, periodic, or one repeated byte
  task automatic make_pattern(int kind);
    logic [BYTE_W-1:0] sym_a;
    logic [BYTE_W-1:0] sym_b;
    int unsigned period;
    sym_a  = BYTE_W'($urandom);
    sym_b  = BYTE_W'($urandom);
    period = $urandom_range(1, 4);
    for (int i = 0; i < PAT_BYTES; i++) begin
      case (kind)
        0: pat_bytes[i] = BYTE_W'($urandom);
        1: pat_bytes[i] = $urandom_range(0, 1) ? sym_a : sym_b;
        2: pat_bytes[i] = (i < period) ? BYTE_W'($urandom) : pat_bytes[i - period];
        default: pat_bytes[i] = sym_a;
      endcase
    end
  endtask

  // next stretch of text: whole occurrences, broken prefixes, pattern
  // symbols, or plain noise
  task automatic add_text;
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      for (int k = 0; k < pat_len_eff; k++) text_q.push_back(pat_bytes[k]);
    end else if (r < 65) begin
      n = $urandom_range(1, pat_len_eff);
      for (int k = 0; k < n; k++) text_q.push_back(pat_bytes[k]);
      text_q.push_back(pat_bytes[$urandom_range(0, PAT_BYTES - 1)]);
    end else if (r < 85) begin
      n = $urandom_range(1, 8);
      repeat (n) text_q.push_back(pat_bytes[$urandom_range(0, pat_len_eff - 1)]);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) text_q.push_back(BYTE_W'($urandom));
    end
  endtask

  initial begin
    foreach (pat_bytes[i]) pat_bytes[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: length one, all-zero pattern
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain_results();

    // length zero behaves as length one
    pat_bytes[0] = 8'hA5;
    write_words();
    set_length(6'd0);
    cfg_valid_i <= 1'b0;
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    drain_results();

    // overlapping occurrences, end of text, then an open prefix
    pat_bytes[0] = 8'h61;
    pat_bytes[1] = 8'h62;
    pat_bytes[2] = 8'h61;
    write_words();
    set_length(6'd3);
    cfg_valid_i <= 1'b0;
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    drain_results();

    // length cut in mid-text leaves a stale automaton state
    set_length(6'd1);
    cfg_valid_i <= 1'b0;
    send_byte(8'h61, 1'b0);
    send_byte(8'h63, 1'b1);
    drain_results();

    // random phases; every fourth changes only the length in mid-text
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p % 4 != 3) begin
        make_pattern($urandom_range(0, 3));
        write_words();
      end
      set_length(phase_len[p]);
      write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), {$urandom, $urandom});
      cfg_valid_i <= 1'b0;
      text_q.delete();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (text_q.size() == 0) add_text();
        send_byte(text_q.pop_front(), $urandom_range(0, 99) < LAST_PCT);
      end
      drain_results();
    end

    // the extra wait catches stray results
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
